// ===== rtl/sparse_page_bitmap_map_macros.svh =====
// Assertion helpers shared by the bitmap map modules
`ifndef SPARSE_PAGE_BITMAP_MAP_MACROS_SVH
`define SPARSE_PAGE_BITMAP_MAP_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SPBM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define SPBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spbm_pkg.sv =====
`timescale 1ns / 1ps
package spbm_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAX_PAGES_DEF  = 262144;
    localparam int ROW_BITS       = 32;
    localparam int ROW_SHIFT      = 5;
    localparam int COUNT_W        = 19;
    localparam int START_W        = 40;
    localparam int OFFSET_W       = 41;
    localparam int RUN_W          = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Request kinds
    localparam logic [1:0] REQ_KEY    = 2'd0;
    localparam logic [1:0] REQ_EMPTY  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_RUN    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LOAD_DONE = 2'd1;
    localparam logic [1:0] ST_CORRUPT   = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TOTAL_PAGES = 1'b0;
    localparam logic CFG_DATA_START  = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  key_byte;
        logic [17:0] page_number;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                present;
        logic [COUNT_W-1:0]  page_rank;
        logic [OFFSET_W-1:0] file_offset;
        logic [COUNT_W-1:0]  run_length;
    } res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_KEY_RD,
        S_KEY_WR,
        S_RANK_RD,
        S_RANK_ACC,
        S_RUN_RD,
        S_RUN_ACC,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        K_IMM,
        K_KEYSET,
        K_RANK,
        K_RUN
    } kind_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic clear_step;
        logic key_rd;
        logic key_wr;
        logic rank_rd;
        logic rank_acc;
        logic run_rd;
        logic run_acc;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  clear_last;
        logic  rank_last;
        logic  run_stop;
    } ctrl_stat_t;

    // Count the set bits of one bitmap row
    function automatic logic [5:0] popcount32(input logic [31:0] x);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++)
        begin
            n = n + 6'(x[i]);
        end
        return n;
    endfunction

    // Count leading zeros of one row, 32 for an all-zero row
    function automatic logic [5:0] clz32(input logic [31:0] x);
        logic [31:0] v;
        logic [5:0]  n;
        v = x;
        n = '0;
        if (v == '0)
        begin
            n = 6'd32;
        end
        else
        begin
            if (v[31:16] == '0)
            begin
                n = n + 6'd16;
                v = v << 16;
            end
            if (v[31:24] == '0)
            begin
                n = n + 6'd8;
                v = v << 8;
            end
            if (v[31:28] == '0)
            begin
                n = n + 6'd4;
                v = v << 4;
            end
            if (v[31:30] == '0)
            begin
                n = n + 6'd2;
                v = v << 2;
            end
            if (!v[31])
            begin
                n = n + 6'd1;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/spbm_ctrl.sv =====
`timescale 1ns / 1ps
`include "sparse_page_bitmap_map_macros.svh"
module spbm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  spbm_pkg::ctrl_stat_t  stat,
    output spbm_pkg::ctrl_cmd_t   cmd
);
    import spbm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.kind)
                    K_KEYSET: state_next = S_KEY_RD;
                    K_RANK:   state_next = S_RANK_RD;
                    K_RUN:    state_next = S_RUN_RD;
                    default:  state_next = S_FINISH;
                endcase
            end
            S_KEY_RD:   state_next = S_KEY_WR;
            S_KEY_WR:   state_next = S_FINISH;
            S_RANK_RD:  state_next = S_RANK_ACC;
            S_RANK_ACC: state_next = stat.rank_last ? S_FINISH : S_RANK_RD;
            S_RUN_RD:   state_next = S_RUN_ACC;
            S_RUN_ACC:  state_next = stat.run_stop ? S_FINISH : S_RUN_RD;
            S_FINISH:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:    cmd.clear_step = 1'b1;
            S_IDLE:     cmd.accept     = start;
            S_DECODE:   cmd.init       = 1'b1;
            S_KEY_RD:   cmd.key_rd     = 1'b1;
            S_KEY_WR:   cmd.key_wr     = 1'b1;
            S_RANK_RD:  cmd.rank_rd    = 1'b1;
            S_RANK_ACC: cmd.rank_acc   = 1'b1;
            S_RUN_RD:   cmd.run_rd     = 1'b1;
            S_RUN_ACC:  cmd.run_acc    = 1'b1;
            S_FINISH:   cmd.finish     = 1'b1;
            default:    cmd            = '0;
        endcase
    end

    `SPBM_ASSERT_NEXT(a_accept_decode, (state_reg == S_IDLE) && start, state_reg == S_DECODE, "accepted item not decoded")
    `SPBM_ASSERT_NEXT(a_finish_idle, state_reg == S_FINISH, state_reg == S_IDLE, "finish did not return to idle")
    `SPBM_ASSERT_NEXT(a_clear_once, state_reg != S_CLEAR, state_reg != S_CLEAR, "clearing pass re-entered")

endmodule

// ===== rtl/spbm_dpath.sv =====
`timescale 1ns / 1ps
`include "sparse_page_bitmap_map_macros.svh"
module spbm_dpath #(
    parameter int PAGE_BYTES = spbm_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = spbm_pkg::MAX_PAGES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spbm_pkg::req_t        request,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [39:0]           cfg_data,
    input  spbm_pkg::ctrl_cmd_t   cmd,
    output spbm_pkg::ctrl_stat_t  stat,
    output logic                  done,
    output spbm_pkg::res_t        result
);
    import spbm_pkg::*;

    localparam int ROWS     = MAX_PAGES / ROW_BITS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int PW       = ROW_W + ROW_SHIFT;
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);

    // Bitmap store, one row of 32 pages, first page in the top bit
    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;

    req_t                req_reg;
    logic [COUNT_W-1:0]  total_pages_reg;
    logic [START_W-1:0]  data_start_reg;
    logic [COUNT_W-1:0]  load_count_reg;
    logic [COUNT_W-1:0]  load_count_next;
    logic                load_done_reg;
    logic                load_done_next;
    logic [ROW_W-1:0]    clr_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [RUN_W-1:0]    acc_reg;
    logic [RUN_W-1:0]    acc_next;
    logic [RUN_W-1:0]    pos_reg;
    logic                want_reg;
    logic                first_reg;
    logic                done_reg;
    res_t                result_reg;
    res_t                result_next;

    kind_t               kind_sel;
    logic                rank_last;
    logic                run_stop;
    logic                clear_last;
    logic [COUNT_W-1:0]  lim;
    logic [PW-1:0]       p_idx;
    logic [PW-1:0]       lc_idx;
    logic [PW-1:0]       pos_idx;
    logic [ROW_W-1:0]    target_row;
    logic [4:0]          part;
    logic                p_in_range;
    logic                is_load;
    logic                corrupt;
    logic [COUNT_W-1:0]  lc_inc;
    logic [RUN_W-1:0]    grp_sum;
    logic [COUNT_W-1:0]  lc_new;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_wa;
    logic [ROW_W-1:0]    mem_ra;
    logic [ROW_BITS-1:0] mem_wd;
    logic                mem_re;
    logic [ROW_BITS-1:0] rank_word;
    logic [ROW_BITS-1:0] rank_mask;
    logic [4:0]          run_off;
    logic                want_cur;
    logic [ROW_BITS-1:0] run_x;
    logic [5:0]          run_lz;
    logic [5:0]          run_avail;
    logic [5:0]          run_neq;
    logic [RUN_W-1:0]    pos_adv;
    logic [COUNT_W-1:0]  run_room;
    logic [RUN_W-1:0]    run_len;
    logic [OFFSET_W-1:0] offset_sum;

    // Decode the held item
    always_comb
    begin
        lim = (25'(total_pages_reg) < 25'(MAX_PAGES)) ? total_pages_reg
                                                      : COUNT_W'(MAX_PAGES);
        p_idx      = PW'(req_reg.page_number);
        lc_idx     = PW'(load_count_reg);
        pos_idx    = PW'(pos_reg);
        target_row = p_idx[PW-1:ROW_SHIFT];
        part       = p_idx[4:0];
        p_in_range = ({1'b0, req_reg.page_number} < lim);
        is_load    = (req_reg.req_type == REQ_KEY) || (req_reg.req_type == REQ_EMPTY);
        corrupt    = (load_count_reg >> 3) >= (lim >> 3);
        lc_inc     = load_count_reg + 1'b1;
        grp_sum    = {1'b0, load_count_reg} + RUN_W'(PAGE_BYTES);
        if (req_reg.req_type == REQ_KEY)
        begin
            lc_new = lc_inc;
        end
        else
        begin
            lc_new = grp_sum[COUNT_W] ? COUNT_MAX : grp_sum[COUNT_W-1:0];
        end
        kind_sel = K_IMM;
        if ((req_reg.req_type == REQ_KEY) && !load_done_reg && !corrupt
            && req_reg.key_byte[0])
        begin
            kind_sel = K_KEYSET;
        end
        else if ((req_reg.req_type == REQ_LOOKUP) && p_in_range)
        begin
            kind_sel = K_RANK;
        end
        else if ((req_reg.req_type == REQ_RUN) && p_in_range)
        begin
            kind_sel = K_RUN;
        end
    end

    // Count set bits of one row for the rank walk
    always_comb
    begin
        rank_last = (row_reg == target_row);
        rank_mask = ~({ROW_BITS{1'b1}} >> part);
        rank_word = rank_last ? (rd_data_reg & rank_mask) : rd_data_reg;
    end

    // Measure the equal-bit stretch of one row for the run walk
    always_comb
    begin
        run_off   = pos_idx[4:0];
        want_cur  = first_reg ? rd_data_reg[5'd31 - run_off] : want_reg;
        run_x     = (rd_data_reg ^ {ROW_BITS{want_cur}}) << run_off;
        run_lz    = clz32(run_x);
        run_avail = 6'd32 - {1'b0, run_off};
        run_neq   = (run_lz < run_avail) ? run_lz : run_avail;
        pos_adv   = pos_reg + RUN_W'(run_avail);
        run_stop  = (run_lz < run_avail) || (pos_adv >= {1'b0, lim});
    end

    // Select the accumulator update
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.init)
        begin
            acc_next = '0;
        end
        else if (cmd.rank_acc)
        begin
            acc_next = acc_reg + RUN_W'(popcount32(rank_word));
        end
        else if (cmd.run_acc)
        begin
            acc_next = acc_reg + RUN_W'(run_neq);
        end
    end

    // Drive the bitmap store ports
    always_comb
    begin
        mem_we = cmd.clear_step || cmd.key_wr;
        mem_wa = cmd.clear_step ? clr_reg : lc_idx[PW-1:ROW_SHIFT];
        mem_wd = cmd.clear_step ? '0
                                : (rd_data_reg | ({1'b1, {(ROW_BITS-1){1'b0}}} >> lc_idx[4:0]));
        mem_re = cmd.key_rd || cmd.rank_rd || cmd.run_rd;
        if (cmd.key_rd)
        begin
            mem_ra = lc_idx[PW-1:ROW_SHIFT];
        end
        else if (cmd.rank_rd)
        begin
            mem_ra = row_reg;
        end
        else
        begin
            mem_ra = pos_idx[PW-1:ROW_SHIFT];
        end
        clear_last = (clr_reg == ROW_W'(ROWS - 1));
    end

    // Report status to the controller
    assign stat = {kind_sel, clear_last, rank_last, run_stop};

    // Write and read the bitmap store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Build the result of the held item
    always_comb
    begin
        load_count_next = load_count_reg;
        load_done_next  = load_done_reg;
        result_next     = '0;
        run_room        = lim - {1'b0, req_reg.page_number};
        run_len         = (acc_reg < {1'b0, run_room}) ? acc_reg : {1'b0, run_room};
        offset_sum      = {1'b0, data_start_reg} + (OFFSET_W'(acc_reg) << PB_SHIFT);
        if (is_load)
        begin
            if (load_done_reg)
            begin
                result_next.status = ST_IGNORED;
            end
            else if ((req_reg.req_type == REQ_KEY) && corrupt)
            begin
                result_next.status = ST_CORRUPT;
            end
            else
            begin
                load_count_next = lc_new;
                if (lc_new >= total_pages_reg)
                begin
                    load_done_next     = 1'b1;
                    result_next.status = ST_LOAD_DONE;
                end
            end
        end
        else if (!p_in_range)
        begin
            result_next.status = ST_IGNORED;
        end
        else if (req_reg.req_type == REQ_LOOKUP)
        begin
            result_next.present     = want_reg;
            result_next.page_rank   = acc_reg[COUNT_W-1:0];
            result_next.file_offset = want_reg ? offset_sum : '0;
        end
        else
        begin
            result_next.present    = want_reg;
            result_next.run_length = run_len[COUNT_W-1:0];
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= '0;
            data_start_reg  <= '0;
            load_count_reg  <= '0;
            load_done_reg   <= 1'b0;
            clr_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_TOTAL_PAGES))
            begin
                total_pages_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_DATA_START))
            begin
                data_start_reg <= cfg_data[START_W-1:0];
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                load_count_reg <= load_count_next;
                load_done_reg  <= load_done_next;
            end
            done_reg <= cmd.finish;
        end
    end

    // Hold the item and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        acc_reg <= acc_next;
        if (cmd.init)
        begin
            row_reg   <= '0;
            pos_reg   <= RUN_W'(req_reg.page_number);
            first_reg <= 1'b1;
        end
        if (cmd.rank_acc)
        begin
            row_reg <= row_reg + 1'b1;
            if (rank_last)
            begin
                want_reg <= rd_data_reg[5'd31 - part];
            end
        end
        if (cmd.run_acc)
        begin
            want_reg  <= want_cur;
            first_reg <= 1'b0;
            pos_reg   <= pos_adv;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SPBM_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "result strobe held two cycles")
    `SPBM_ASSERT_NEXT(a_load_sticky, load_done_reg, load_done_reg, "load completion dropped")
    `SPBM_ASSERT_SAME(a_no_write_after_load, cmd.key_wr, !load_done_reg, "bitmap written after load")

endmodule

// ===== rtl/sparse_page_bitmap_map.sv =====
// Key byte with bit0 set during the load: decode, row read, row write, finish, then the strobe;
// other loads go from decode to finish. Lookup: a read and an accumulate step per 32-page row,
// from row 0 up to the page's row. Run query: the same row walk from the page's row to run end.
// Out of range queries go from decode to finish. One item at a time; start is taken again in
// the cycle the result strobe shows. Reset: asynchronous, active low; a clearing pass zeroes
// the bitmap row by row while busy stays high. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module sparse_page_bitmap_map #(
    parameter int PAGE_BYTES = spbm_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = spbm_pkg::MAX_PAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  spbm_pkg::req_t  request,
    output logic            done,
    output spbm_pkg::res_t  result,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [39:0]     cfg_data
);
    import spbm_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Sequence each item
    spbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Hold bitmap, counters and results
    spbm_dpath #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule
